>>> hw/rtl/hdt_pkg.sv
// Shared types, constants and step tables for the heading and distance block.
`timescale 1ns / 1ps

package hdt_pkg;

    // Geometry and pipeline sizing
    localparam int COORD_BITS    = 16;
    localparam int CORDIC_STAGES = 16;
    localparam int TABLE_LEN     = 24;
    localparam int GUARD_BITS    = 20;
    localparam int ANG_FRAC      = 24;

    localparam int ROT_STAGES = (CORDIC_STAGES < TABLE_LEN) ? CORDIC_STAGES : TABLE_LEN;

    // CORDIC datapath: |d| << GUARD plus growth and sign
    localparam int XW = COORD_BITS + GUARD_BITS + 3;
    localparam int ZW = 27;           // signed Q.24 angle accumulator
    localparam int MW = 26;           // unsigned Q.24 angle in [0, pi]

    // Square root datapath
    localparam int SW  = 2 * COORD_BITS + 1;   // dx^2 + dy^2
    localparam int SQW = (SW + 1) / 2;         // root digits
    localparam int RW  = SW + 1;

    localparam int NCELLS = (ROT_STAGES > SQW) ? ROT_STAGES : SQW;

    // Output formats
    localparam int HEAD_BITS = 16;
    localparam int DIST_BITS = 17;
    localparam int DIST_MAX  = 131071;
    localparam int CMPW      = (COORD_BITS > DIST_BITS) ? COORD_BITS : DIST_BITS;

    localparam int PI_Q24      = 52707179;
    localparam int HALF_PI_Q24 = 26353589;
    localparam int ANG_SHIFT   = ANG_FRAC - 13;          // Q.24 -> Q2.13
    localparam int ROUND_ADD   = 1 << (ANG_FRAC - 14);

    typedef struct packed {
        logic signed [COORD_BITS-1:0] start_x;
        logic signed [COORD_BITS-1:0] start_y;
        logic signed [COORD_BITS-1:0] target_x;
        logic signed [COORD_BITS-1:0] target_y;
    } t_in_req;

    typedef struct packed {
        logic signed [HEAD_BITS-1:0] heading;
        logic [DIST_BITS-1:0]        distance;
    } t_out_req;

    typedef struct packed {
        logic dx_neg;
        logic dy_neg;
        logic ax_zero;
        logic ay_zero;
        logic sat;
    } t_flags;

    typedef struct packed {
        logic signed [XW-1:0] x;
        logic signed [XW-1:0] y;
        logic signed [ZW-1:0] z;
        logic [SW-1:0]        rem;
        logic [SW-1:0]        root;
        t_flags               flags;
    } t_cell_data;

    // Per-cell constants, fixed by the cell's place in the row
    typedef struct packed {
        logic [4:0]           shift;
        logic signed [ZW-1:0] atan;
        logic [SW-1:0]        sq_bit;
        logic                 rot_on;
        logic                 sqrt_on;
    } t_step;

    // atan(2^-i) in Q.24, rounded to nearest
    function automatic logic signed [ZW-1:0] atan_q24(input int idx);
        logic signed [ZW-1:0] v;
        case (idx)
            0:       v = ZW'(13176795);
            1:       v = ZW'(7778716);
            2:       v = ZW'(4110060);
            3:       v = ZW'(2086331);
            4:       v = ZW'(1047214);
            5:       v = ZW'(524117);
            6:       v = ZW'(262123);
            7:       v = ZW'(131069);
            8:       v = ZW'(65536);
            9:       v = ZW'(32768);
            10:      v = ZW'(16384);
            11:      v = ZW'(8192);
            12:      v = ZW'(4096);
            13:      v = ZW'(2048);
            14:      v = ZW'(1024);
            15:      v = ZW'(512);
            16:      v = ZW'(256);
            17:      v = ZW'(128);
            18:      v = ZW'(64);
            19:      v = ZW'(32);
            20:      v = ZW'(16);
            21:      v = ZW'(8);
            22:      v = ZW'(4);
            23:      v = ZW'(2);
            default: v = '0;
        endcase
        return v;
    endfunction

    function automatic t_step cell_step(input int k);
        t_step s;
        s = '0;
        if (k < ROT_STAGES) begin
            s.rot_on = 1'b1;
            s.shift  = 5'(k);
            s.atan   = atan_q24(k);
        end
        if (k < SQW) begin
            s.sqrt_on = 1'b1;
            s.sq_bit  = SW'(1) << (2 * (SQW - 1 - k));
        end
        return s;
    endfunction

endpackage

>>> hw/rtl/hdt_front.sv
// Front end: differences, magnitudes, squares and cell-row seed values.
`timescale 1ns / 1ps

module hdt_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  logic                 i_valid,
    input  hdt_pkg::t_in_req     i_req,
    output logic                 o_valid,
    output hdt_pkg::t_cell_data  o_data
);

    localparam int CB = hdt_pkg::COORD_BITS;

    // stage A: |dx|, |dy| and flags
    logic signed [CB:0] dx, dy;
    logic [CB-1:0]      ax_c, ay_c;
    logic               r_valid_a;
    logic [CB-1:0]      r_ax_a, r_ay_a;
    hdt_pkg::t_flags    r_flags_a;

    // stage B: squares
    logic               r_valid_b;
    logic [CB-1:0]      r_ax_b, r_ay_b;
    logic [2*CB-1:0]    r_sqx_b, r_sqy_b;
    hdt_pkg::t_flags    r_flags_b;

    // stage C: seed
    logic               r_valid_c;
    hdt_pkg::t_cell_data r_data_c;

    logic [hdt_pkg::XW-1:0] x_seed, y_seed;

    assign dx = {i_req.target_x[CB-1], i_req.target_x} - {i_req.start_x[CB-1], i_req.start_x};
    assign dy = {i_req.target_y[CB-1], i_req.target_y} - {i_req.start_y[CB-1], i_req.start_y};

    always_comb begin
        logic [CB:0] nx, ny;
        nx   = dx[CB] ? (-dx) : dx;
        ny   = dy[CB] ? (-dy) : dy;
        ax_c = nx[CB-1:0];
        ay_c = ny[CB-1:0];
    end

    assign x_seed = hdt_pkg::XW'(r_ax_b) << hdt_pkg::GUARD_BITS;
    assign y_seed = hdt_pkg::XW'(r_ay_b) << hdt_pkg::GUARD_BITS;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid_a <= 1'b0;
            r_valid_b <= 1'b0;
            r_valid_c <= 1'b0;
        end else if (i_en) begin
            r_valid_a <= i_valid;
            r_valid_b <= r_valid_a;
            r_valid_c <= r_valid_b;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ax_a            <= ax_c;
            r_ay_a            <= ay_c;
            r_flags_a.dx_neg  <= dx[CB];
            r_flags_a.dy_neg  <= dy[CB];
            r_flags_a.ax_zero <= (ax_c == '0);
            r_flags_a.ay_zero <= (ay_c == '0);
            r_flags_a.sat     <= (hdt_pkg::CMPW'(ax_c) > hdt_pkg::CMPW'(hdt_pkg::DIST_MAX))
                              || (hdt_pkg::CMPW'(ay_c) > hdt_pkg::CMPW'(hdt_pkg::DIST_MAX));

            r_ax_b    <= r_ax_a;
            r_ay_b    <= r_ay_a;
            r_sqx_b   <= r_ax_a * r_ax_a;
            r_sqy_b   <= r_ay_a * r_ay_a;
            r_flags_b <= r_flags_a;

            r_data_c.x     <= signed'(x_seed);
            r_data_c.y     <= signed'(y_seed);
            r_data_c.z     <= '0;
            r_data_c.rem   <= {1'b0, r_sqx_b} + {1'b0, r_sqy_b};
            r_data_c.root  <= '0;
            r_data_c.flags <= r_flags_b;
        end
    end

    assign o_valid = r_valid_c;
    assign o_data  = r_data_c;

endmodule

>>> hw/rtl/hdt_cell.sv
// One cell of the row: a CORDIC vectoring rotation and one square-root digit.
`timescale 1ns / 1ps

module hdt_cell (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  hdt_pkg::t_step       i_step,
    input  logic                 i_valid,
    input  hdt_pkg::t_cell_data  i_data,
    output logic                 o_valid,
    output hdt_pkg::t_cell_data  o_data
);

    localparam int XW = hdt_pkg::XW;
    localparam int SW = hdt_pkg::SW;

    logic                r_valid;
    hdt_pkg::t_cell_data r_data;
    hdt_pkg::t_cell_data n_data;

    logic signed [XW-1:0] x_in, y_in, xs, ys;
    logic [SW:0]          trial;
    logic                 take;

    assign x_in  = i_data.x;
    assign y_in  = i_data.y;
    assign xs    = x_in >>> i_step.shift;
    assign ys    = y_in >>> i_step.shift;
    assign trial = {1'b0, i_data.root} + {1'b0, i_step.sq_bit};
    assign take  = ({1'b0, i_data.rem} >= trial);

    always_comb begin
        n_data = i_data;
        if (i_step.rot_on) begin
            // y >= 0: rotate clockwise, angle grows
            if (!y_in[XW-1]) begin
                n_data.x = x_in + ys;
                n_data.y = y_in - xs;
                n_data.z = i_data.z + i_step.atan;
            end else begin
                n_data.x = x_in - ys;
                n_data.y = y_in + xs;
                n_data.z = i_data.z - i_step.atan;
            end
        end
        if (i_step.sqrt_on) begin
            if (take) begin
                n_data.rem  = i_data.rem - trial[SW-1:0];
                n_data.root = (i_data.root >> 1) + i_step.sq_bit;
            end else begin
                n_data.root = i_data.root >> 1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

>>> hw/rtl/hdt_back.sv
// Back end: angle clamp and quadrant mapping, root rounding and saturation.
`timescale 1ns / 1ps

module hdt_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  logic                 i_valid,
    input  hdt_pkg::t_cell_data  i_data,
    output logic                 o_valid,
    output hdt_pkg::t_out_req    o_resp
);

    localparam int ZW = hdt_pkg::ZW;
    localparam int MW = hdt_pkg::MW;
    localparam int SW = hdt_pkg::SW;
    localparam int RW = hdt_pkg::RW;
    localparam int HW = MW - hdt_pkg::ANG_SHIFT;

    logic [MW-1:0] z_clamp, a_sel, m_c;
    logic [MW-1:0] h_sum;
    logic [RW-1:0] root_up;

    // stage 1
    logic          r_valid_1;
    logic [MW-1:0] r_m_1;
    logic [SW-1:0] r_root_1;
    logic          r_up_1, r_dy_neg_1, r_sat_1;

    // stage 2
    logic          r_valid_2;
    logic [HW-1:0] r_hmag_2;
    logic [RW-1:0] r_root_2;
    logic          r_dy_neg_2, r_sat_2;

    // stage 3
    logic               r_valid_3;
    hdt_pkg::t_out_req  r_resp_3;

    always_comb begin
        if (i_data.z[ZW-1]) begin
            z_clamp = '0;
        end else if (i_data.z > ZW'(hdt_pkg::HALF_PI_Q24)) begin
            z_clamp = MW'(hdt_pkg::HALF_PI_Q24);
        end else begin
            z_clamp = i_data.z[MW-1:0];
        end
        // on an axis the angle is exact
        if (i_data.flags.ay_zero) begin
            a_sel = '0;
        end else if (i_data.flags.ax_zero) begin
            a_sel = MW'(hdt_pkg::HALF_PI_Q24);
        end else begin
            a_sel = z_clamp;
        end
        m_c = i_data.flags.dx_neg ? (MW'(hdt_pkg::PI_Q24) - a_sel) : a_sel;
    end

    assign h_sum   = r_m_1 + MW'(hdt_pkg::ROUND_ADD);
    assign root_up = {1'b0, r_root_1} + RW'(r_up_1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid_1 <= 1'b0;
            r_valid_2 <= 1'b0;
            r_valid_3 <= 1'b0;
        end else if (i_en) begin
            r_valid_1 <= i_valid;
            r_valid_2 <= r_valid_1;
            r_valid_3 <= r_valid_2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_m_1      <= m_c;
            r_root_1   <= i_data.root;
            r_up_1     <= (i_data.rem > i_data.root);   // s > root^2 + root
            r_dy_neg_1 <= i_data.flags.dy_neg;
            r_sat_1    <= i_data.flags.sat;

            r_hmag_2   <= h_sum[MW-1:hdt_pkg::ANG_SHIFT];
            r_root_2   <= root_up;
            r_dy_neg_2 <= r_dy_neg_1;
            r_sat_2    <= r_sat_1;

            r_resp_3.heading <= r_dy_neg_2 ? -hdt_pkg::HEAD_BITS'({1'b0, r_hmag_2})
                                           :  hdt_pkg::HEAD_BITS'({1'b0, r_hmag_2});
            if (r_sat_2 || (r_root_2 > RW'(hdt_pkg::DIST_MAX))) begin
                r_resp_3.distance <= hdt_pkg::DIST_BITS'(hdt_pkg::DIST_MAX);
            end else begin
                r_resp_3.distance <= r_root_2[hdt_pkg::DIST_BITS-1:0];
            end
        end
    end

    assign o_valid = r_valid_3;
    assign o_resp  = r_resp_3;

endmodule

>>> hw/rtl/heading_and_distance_to_target.sv
// Top level: heading and distance from a start point to a target point.
`timescale 1ns / 1ps
//
// Use:
//   Input channel  i_in_valid / o_in_ready / i_in_req  : start and target points,
//   signed millimetres. Output channel o_out_valid / i_out_ready / o_out_req :
//   heading (Q2.13 radians, atan2 convention) and rounded distance (mm).
//   A request moves when valid and ready are both high at a rising edge.
// Path from accept to o_out_valid: three front stages, one cell per CORDIC
//   rotation or root digit (whichever row is longer), three back stages and
//   the output register.
// Throughput: one request per cycle while the skid is free; the row of cells is fully pipelined.
// Reset (i_rst_n low, synchronous): all valid bits clear, the pipe is empty.
//   There is no other state.
// Receiver stall: the output register holds its result; one more result is
//   caught in a skid register, and only then does o_in_ready drop and the
//   whole pipe hold. o_in_ready is a register output.
//
module heading_and_distance_to_target (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  hdt_pkg::t_in_req    i_in_req,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output hdt_pkg::t_out_req   o_out_req
);

    localparam int NC = hdt_pkg::NCELLS;

    logic                en;
    logic                front_valid;
    hdt_pkg::t_cell_data front_data;

    // cell row links
    logic                cell_valid [0:NC];
    hdt_pkg::t_cell_data cell_data  [0:NC];

    logic                back_valid;
    hdt_pkg::t_out_req   back_resp;

    // output register and skid
    logic              r_out_valid, n_out_valid;
    logic              r_skid_valid, n_skid_valid;
    hdt_pkg::t_out_req r_out, r_skid;
    logic              load_out, load_skid, out_from_skid;
    logic              pop;

    // whole pipe advances while the skid is free
    assign en         = !r_skid_valid;
    assign o_in_ready = en;
    assign pop        = en && back_valid;

    hdt_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (i_in_valid),
        .i_req   (i_in_req),
        .o_valid (front_valid),
        .o_data  (front_data)
    );

    assign cell_valid[0] = front_valid;
    assign cell_data[0]  = front_data;

    for (genvar k = 0; k < NC; k++) begin : g_cell
        localparam hdt_pkg::t_step STEP = hdt_pkg::cell_step(k);
        hdt_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_step  (STEP),
            .i_valid (cell_valid[k]),
            .i_data  (cell_data[k]),
            .o_valid (cell_valid[k+1]),
            .o_data  (cell_data[k+1])
        );
    end

    hdt_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (cell_valid[NC]),
        .i_data  (cell_data[NC]),
        .o_valid (back_valid),
        .o_resp  (back_resp)
    );

    always_comb begin
        n_out_valid   = r_out_valid;
        n_skid_valid  = r_skid_valid;
        load_out      = 1'b0;
        load_skid     = 1'b0;
        out_from_skid = 1'b0;
        if (!r_out_valid || i_out_ready) begin
            // output slot free this cycle
            if (r_skid_valid) begin
                load_out      = 1'b1;
                out_from_skid = 1'b1;
                n_out_valid   = 1'b1;
                n_skid_valid  = 1'b0;
            end else if (pop) begin
                load_out    = 1'b1;
                n_out_valid = 1'b1;
            end else begin
                n_out_valid = 1'b0;
            end
        end else if (pop) begin
            // output held by the receiver: park the new result
            load_skid    = 1'b1;
            n_skid_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_out <= out_from_skid ? r_skid : back_resp;
        end
        if (load_skid) begin
            r_skid <= back_resp;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_req   = r_out;

endmodule
